[rtl/fcp_pkg.sv]
// shared types, codes and constants of the fly camera pose integrator
package fcp_pkg;

    // request kinds carried in tuser
    localparam logic [2:0] REQ_ROTATE   = 3'd0;
    localparam logic [2:0] REQ_FORWARD  = 3'd1;
    localparam logic [2:0] REQ_BACKWARD = 3'd2;
    localparam logic [2:0] REQ_LEFT     = 3'd3;
    localparam logic [2:0] REQ_RIGHT    = 3'd4;
    localparam logic [2:0] REQ_UP       = 3'd5;
    localparam logic [2:0] REQ_DOWN     = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_MOVE_SPEED  = 2'd0;
    localparam logic [1:0] CFG_SPRINT_GAIN = 2'd1;
    localparam logic [1:0] CFG_LOOK_SENS   = 2'd2;

    // register reset values
    localparam logic [15:0] MOVE_SPEED_RST  = 16'd1280;
    localparam logic [7:0]  SPRINT_GAIN_RST = 8'd32;
    localparam logic [15:0] LOOK_SENS_RST   = 16'd5340;

    // pitch limit of 89 degrees in Q16.8 angle units
    localparam logic signed [34:0] PITCH_LIMIT = 35'sd4147712;

    // cordic start vector, gain compensated, Q2.30
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // one unit step along y for up and down moves
    localparam logic signed [18:0] UNIT_Y = 19'sd65536;

    // cordic controls between sequencer and rotation unit
    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic               done;
        logic signed [17:0] cos_v;
        logic signed [17:0] sin_v;
    } cordic_rsp_t;

    // arctangent of 2^-i, 2^32 per turn
    function automatic logic [29:0] atan_turn32(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/fly_camera_pose_integrator.sv]
// top level: request sequencer, shared multiplier and pose registers
//
// Camera pose integrator. Requests arrive on the s_ stream (tuser holds the
// request kind, tdata the mouse deltas, frame time and sprint flag); every
// accepted request returns exactly one pose on the m_ stream.
// Registers are written through cfg_we / cfg_index / cfg_wdata; the user
// must write them only while idle, the block itself does not enforce it.
// One request is worked at a time; s_tready is high only when the sequencer
// is idle. A rotate request uses the multiplier only, an unused kind goes
// straight to the output, up / down need no cordic pass, left / right take
// one cordic pass for the yaw and forward / backward a second one for the
// pitch. The shared cordic unit does one micro-rotation per cycle, and the
// single registered multiplier one product per cycle.
// The finished pose sits in an output register, so a new request can be
// taken while the receiver stalls; the sequencer only waits at its last
// step if the previous pose has not been taken yet.
// Reset clears the pose to zero and loads the register defaults.
module fly_camera_pose_integrator #(
    parameter int CORDIC_STEPS = 16,
    parameter int POS_WIDTH    = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,  // mouse_dx, mouse_dy, frame_dt, sprint, zero fill
    input  logic [2:0]   s_tuser,  // req_type
    // pose stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,  // pos_x, pos_y, pos_z, view_yaw, view_pitch, moved
    // configuration writes
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata
);

    localparam int SW = ((POS_WIDTH > 33) ? POS_WIDTH : 33) + 1;
    localparam logic signed [SW-1:0] POS_HI =
        signed'({{(SW - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}});
    localparam logic signed [SW-1:0] POS_LO = ~POS_HI;

    typedef enum logic [18:0] {
        ST_IDLE    = 19'b0000000000000000001,
        ST_ROT_X   = 19'b0000000000000000010,
        ST_ROT_Y   = 19'b0000000000000000100,
        ST_ROT_P   = 19'b0000000000000001000,
        ST_STEP    = 19'b0000000000000010000,
        ST_SPR     = 19'b0000000000000100000,
        ST_SGN     = 19'b0000000000001000000,
        ST_CY_GO   = 19'b0000000000010000000,
        ST_CY_WAIT = 19'b0000000000100000000,
        ST_CP_GO   = 19'b0000000001000000000,
        ST_CP_WAIT = 19'b0000000010000000000,
        ST_DIR_X   = 19'b0000000100000000000,
        ST_DIR_Z   = 19'b0000001000000000000,
        ST_DIR_W   = 19'b0000010000000000000,
        ST_POS_X   = 19'b0000100000000000000,
        ST_POS_Y   = 19'b0001000000000000000,
        ST_POS_Z   = 19'b0010000000000000000,
        ST_POS_W   = 19'b0100000000000000000,
        ST_DONE    = 19'b1000000000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [15:0] speed_reg;
    logic [7:0]  gain_reg;
    logic [15:0] sens_reg;

    // pose
    logic [23:0]                  yaw_reg;
    logic signed [23:0]           pitch_reg;
    logic signed [POS_WIDTH-1:0]  px_reg, py_reg, pz_reg;

    // latched request
    logic [2:0]          kind_reg;
    logic signed [15:0]  dx_reg, dy_reg;
    logic [15:0]         dt_reg;
    logic                sprint_reg;
    logic                moved_reg;

    // working registers
    logic [31:0]         step_lo_reg;
    logic signed [37:0]  step_reg;
    logic signed [17:0]  cy_reg, sy_reg, cp_reg, spt_reg;
    logic signed [18:0]  dirx_reg, diry_reg, dirz_reg;

    // shared multiplier
    logic signed [37:0]  mul_a;
    logic signed [18:0]  mul_b;
    logic signed [56:0]  prod_reg;

    // output stage
    logic                out_valid_reg;
    logic [127:0]        out_data_reg;

    fcp_pkg::cordic_req_t cq;
    fcp_pkg::cordic_rsp_t cr;

    logic                 in_acc;
    logic                 out_load;
    logic signed [34:0]   pitch_sum;
    logic [35:0]          su;
    logic signed [37:0]   su_s;
    logic                 neg_step;
    logic signed [SW-1:0] pos_wide_x, pos_wide_y, pos_wide_z;

    fcp_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (cq),
        .rsp  (cr)
    );

    function automatic logic signed [POS_WIDTH-1:0] sat_add(
        input logic signed [POS_WIDTH-1:0] p,
        input logic signed [56:0]          prod
    );
        logic signed [SW-1:0] r;
        r = SW'(p) + SW'(signed'(prod[56:24]));
        if (r > POS_HI)
            r = POS_HI;
        else if (r < POS_LO)
            r = POS_LO;
        return r[POS_WIDTH-1:0];
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // cordic start and angle
    always_comb
    begin
        cq.start = (state_reg == ST_CY_GO) || (state_reg == ST_CP_GO);
        cq.angle = (state_reg == ST_CP_GO) ? {pitch_reg, 8'h00} : {yaw_reg, 8'h00};
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_ROT_X:
            begin
                mul_a = 38'(dx_reg);
                mul_b = signed'({3'b000, sens_reg});
            end
            ST_ROT_Y:
            begin
                mul_a = 38'(dy_reg);
                mul_b = signed'({3'b000, sens_reg});
            end
            ST_STEP:
            begin
                mul_a = signed'({22'd0, speed_reg});
                mul_b = signed'({3'b000, dt_reg});
            end
            ST_SPR:
            begin
                mul_a = signed'({6'd0, prod_reg[31:0]});
                mul_b = signed'({11'd0, gain_reg});
            end
            ST_DIR_X:
            begin
                mul_a = 38'(sy_reg);
                mul_b = 19'(cp_reg);
            end
            ST_DIR_Z:
            begin
                mul_a = 38'(cy_reg);
                mul_b = 19'(cp_reg);
            end
            ST_POS_X:
            begin
                mul_a = step_reg;
                mul_b = dirx_reg;
            end
            ST_POS_Y:
            begin
                mul_a = step_reg;
                mul_b = diry_reg;
            end
            ST_POS_Z:
            begin
                mul_a = step_reg;
                mul_b = dirz_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 57'(mul_a * mul_b);
    end

    // rotate and step arithmetic
    assign pitch_sum = 35'(pitch_reg) - 35'(signed'(prod_reg[32:0]));
    assign su        = sprint_reg ? prod_reg[39:4] : {4'h0, step_lo_reg};
    assign neg_step  = (kind_reg == fcp_pkg::REQ_BACKWARD) ||
                       (kind_reg == fcp_pkg::REQ_LEFT) ||
                       (kind_reg == fcp_pkg::REQ_DOWN);
    assign su_s      = signed'({2'b00, su});

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tuser == fcp_pkg::REQ_ROTATE)
                        state_next = ST_ROT_X;
                    else if (s_tuser == 3'(fcp_pkg::REQ_DOWN + 3'd1))
                        state_next = ST_DONE;
                    else
                        state_next = ST_STEP;
                end
            end
            ST_ROT_X:   state_next = ST_ROT_Y;
            ST_ROT_Y:   state_next = ST_ROT_P;
            ST_ROT_P:   state_next = ST_DONE;
            ST_STEP:    state_next = ST_SPR;
            ST_SPR:     state_next = ST_SGN;
            ST_SGN:
            begin
                if (kind_reg == fcp_pkg::REQ_UP || kind_reg == fcp_pkg::REQ_DOWN)
                    state_next = ST_POS_X;
                else
                    state_next = ST_CY_GO;
            end
            ST_CY_GO:   state_next = ST_CY_WAIT;
            ST_CY_WAIT:
            begin
                if (cr.done)
                begin
                    if (kind_reg == fcp_pkg::REQ_LEFT || kind_reg == fcp_pkg::REQ_RIGHT)
                        state_next = ST_POS_X;
                    else
                        state_next = ST_CP_GO;
                end
            end
            ST_CP_GO:   state_next = ST_CP_WAIT;
            ST_CP_WAIT:
            begin
                if (cr.done)
                    state_next = ST_DIR_X;
            end
            ST_DIR_X:   state_next = ST_DIR_Z;
            ST_DIR_Z:   state_next = ST_DIR_W;
            ST_DIR_W:   state_next = ST_POS_X;
            ST_POS_X:   state_next = ST_POS_Y;
            ST_POS_Y:   state_next = ST_POS_Z;
            ST_POS_Z:   state_next = ST_POS_W;
            ST_POS_W:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // control state, configuration and pose
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            speed_reg     <= fcp_pkg::MOVE_SPEED_RST;
            gain_reg      <= fcp_pkg::SPRINT_GAIN_RST;
            sens_reg      <= fcp_pkg::LOOK_SENS_RST;
            yaw_reg       <= '0;
            pitch_reg     <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            pz_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    fcp_pkg::CFG_MOVE_SPEED:  speed_reg <= cfg_wdata;
                    fcp_pkg::CFG_SPRINT_GAIN: gain_reg  <= cfg_wdata[7:0];
                    fcp_pkg::CFG_LOOK_SENS:   sens_reg  <= cfg_wdata;
                    default:                  ;
                endcase
            end
            case (state_reg)
                ST_ROT_Y: yaw_reg <= yaw_reg + prod_reg[23:0];
                ST_ROT_P:
                begin
                    if (pitch_sum > fcp_pkg::PITCH_LIMIT)
                        pitch_reg <= fcp_pkg::PITCH_LIMIT[23:0];
                    else if (pitch_sum < -fcp_pkg::PITCH_LIMIT)
                        pitch_reg <= 24'(-fcp_pkg::PITCH_LIMIT);
                    else
                        pitch_reg <= pitch_sum[23:0];
                end
                ST_POS_Y: px_reg <= sat_add(px_reg, prod_reg);
                ST_POS_Z: py_reg <= sat_add(py_reg, prod_reg);
                ST_POS_W: pz_reg <= sat_add(pz_reg, prod_reg);
                default:  ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            kind_reg   <= s_tuser;
            dx_reg     <= signed'(s_tdata[15:0]);
            dy_reg     <= signed'(s_tdata[31:16]);
            dt_reg     <= s_tdata[47:32];
            sprint_reg <= s_tdata[48];
            moved_reg  <= (s_tuser != fcp_pkg::REQ_ROTATE) &&
                          (s_tuser != 3'(fcp_pkg::REQ_DOWN + 3'd1));
        end
        case (state_reg)
            ST_SPR: step_lo_reg <= prod_reg[31:0];
            ST_SGN:
            begin
                step_reg <= neg_step ? -su_s : su_s;
                if (kind_reg == fcp_pkg::REQ_UP || kind_reg == fcp_pkg::REQ_DOWN)
                begin
                    dirx_reg <= '0;
                    diry_reg <= fcp_pkg::UNIT_Y;
                    dirz_reg <= '0;
                end
            end
            ST_CY_WAIT:
            begin
                if (cr.done)
                begin
                    cy_reg   <= cr.cos_v;
                    sy_reg   <= cr.sin_v;
                    dirx_reg <= 19'(cr.cos_v);
                    diry_reg <= '0;
                    dirz_reg <= 19'(cr.sin_v);
                end
            end
            ST_CP_WAIT:
            begin
                if (cr.done)
                begin
                    cp_reg  <= cr.cos_v;
                    spt_reg <= cr.sin_v;
                end
            end
            ST_DIR_Z: dirx_reg <= prod_reg[34:16];
            ST_DIR_W:
            begin
                dirz_reg <= -prod_reg[34:16];
                diry_reg <= 19'(spt_reg);
            end
            default: ;
        endcase
        if (out_load)
        begin
            out_data_reg <= {moved_reg, pitch_reg[22:8], yaw_reg[23:8],
                             pos_wide_z[31:0], pos_wide_y[31:0], pos_wide_x[31:0]};
        end
    end

    assign pos_wide_x = SW'(px_reg);
    assign pos_wide_y = SW'(py_reg);
    assign pos_wide_z = SW'(pz_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[rtl/fcp_cordic.sv]
// iterative cordic rotation unit, one micro-rotation per cycle
module fcp_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fcp_pkg::cordic_req_t req,
    output fcp_pkg::cordic_rsp_t rsp
);

    localparam int CW = $clog2(CORDIC_STEPS);

    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [32:0] z_reg, z_next;
    logic               flip_reg, flip_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic signed [32:0] a_s;
    logic signed [33:0] xs, ys, xf, yf;
    logic signed [32:0] atan_v;

    assign a_s    = 33'(signed'(req.angle));
    assign xs     = y_reg >>> cnt_reg;
    assign ys     = x_reg >>> cnt_reg;
    assign atan_v = signed'({3'b000, fcp_pkg::atan_turn32(5'(cnt_reg))});

    // quadrant fold on start, micro-rotations while busy
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        flip_next = flip_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            x_next    = fcp_pkg::CORDIC_GAIN;
            y_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            if (a_s > 33'sd1073741824)
            begin
                z_next    = a_s - 33'sd2147483648;
                flip_next = 1'b1;
            end
            else if (a_s < -33'sd1073741824)
            begin
                z_next    = a_s + 33'sd2147483648;
                flip_next = 1'b1;
            end
            else
            begin
                z_next    = a_s;
                flip_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - xs;
                y_next = y_reg + ys;
                z_next = z_reg - atan_v;
            end
            else
            begin
                x_next = x_reg + xs;
                y_next = y_reg - ys;
                z_next = z_reg + atan_v;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    // undo fold, floor to Q16
    assign xf = flip_reg ? -x_reg : x_reg;
    assign yf = flip_reg ? -y_reg : y_reg;

    assign rsp.done  = done_reg;
    assign rsp.cos_v = xf[31:14];
    assign rsp.sin_v = yf[31:14];

endmodule

[rtl/fcp_checker.sv]
// port-level checker for the fly camera pose integrator, bound to the top
module fcp_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    // a stalled pose stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("pose dropped while stalled");

    // a stalled pose holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("pose changed while stalled");

    // one request at a time: busy after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // no pose in the cycle right after an accept into an empty output
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("pose appeared too early");

endmodule

bind fly_camera_pose_integrator fcp_checker u_fcp_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
